[hdl/baro_pressure_compensation_top_defines.svh]
// Assertion macros shared by the checker of the pressure compensation block
`ifndef BARO_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// antecedent implies consequent on the same edge
`define BPC_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpc: implication check failed");

// condition holds at every edge out of reset
`define BPC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bpc: invariant check failed");

`endif

[hdl/bpc_pkg.sv]
// Types, constants and codes of the pressure compensation pipeline
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int QUOT_W     = 64;
	localparam int DIVISOR_W  = 31;

	// accept edge to strobe, in clock edges
	localparam int PIPE_LATENCY = 80;

	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_PRESENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEF      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C        = 3'd4;

	localparam logic [1:0] STATUS_VALID    = 2'd0;
	localparam logic [1:0] STATUS_ABSENT   = 2'd1;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

	localparam logic [17:0]        PRESS_TOP    = 18'h3FFFF;
	localparam logic signed [22:0] FINE_OFFSET  = 23'sd128000;
	localparam logic signed [63:0] PRESS_OFFSET = 64'sh0000_8000_0000_0000;
	localparam logic [20:0]        ADC_FULL     = 21'd1048576;
	localparam logic [63:0]        NUM_SCALE    = 64'd3125;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] temp_hundredths;
		logic [17:0]        press_pascal;
		logic [1:0]         result_status;
	} result_t;

	typedef struct packed {
		logic        present;
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coef_t;

	// side data riding along with the quotient
	typedef struct packed {
		logic        neg;
		logic [1:0]  status;
		logic [15:0] temp;
	} div_tag_t;

	typedef struct packed {
		logic                 vld;
		div_tag_t             tag;
		logic [QUOT_W-1:0]    dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_in_t;

	typedef struct packed {
		logic              vld;
		div_tag_t          tag;
		logic [QUOT_W-1:0] quotient;
	} div_out_t;

endpackage

[hdl/bpc_front.sv]
// Temperature compensation and pressure divisor/numerator setup, nine stages
`timescale 1ns / 1ps

module bpc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  bpc_pkg::sample_t  sample,
	input  bpc_pkg::coef_t    coef,
	output bpc_pkg::div_in_t  div_in
);

	logic [9:1] vld_s;

	// stage 1
	logic signed [17:0] tdiff1;
	logic signed [16:0] tdiff2;
	logic signed [33:0] x1_full;
	logic signed [33:0] dd_full;
	logic [31:0]        x1_s1;
	logic [31:0]        dd_s1;
	logic [19:0]        adc_p_s1;

	assign tdiff1  = $signed({1'b0, sample.raw_temperature[19:3]})
		- $signed({1'b0, coef.t1, 1'b0});
	assign tdiff2  = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
	assign x1_full = tdiff1 * $signed(coef.t2);
	assign dd_full = tdiff2 * tdiff2;

	// stage 2
	logic signed [19:0] dsh;
	logic signed [35:0] y_full;
	logic signed [20:0] v1_s2;
	logic [31:0]        y_s2;
	logic [19:0]        adc_p_s2;

	assign dsh    = $signed(dd_s1[31:12]);
	assign y_full = dsh * $signed(coef.t3);

	// stage 3
	logic signed [17:0] v2;
	logic signed [21:0] fine;
	logic signed [24:0] fine_x;
	logic signed [24:0] fine5;
	logic signed [22:0] a_full;
	logic [15:0]        temp_s3;
	logic signed [22:0] a_s3;
	logic [19:0]        adc_p_s3;

	assign v2     = $signed(y_s2[31:14]);
	assign fine   = 22'(v1_s2) + 22'(v2);
	assign fine_x = 25'(fine);
	assign fine5  = (fine_x <<< 2) + fine_x + 25'sd128;
	assign a_full = 23'(fine) - bpc_pkg::FINE_OFFSET;

	// stage 4
	logic signed [45:0] aa;
	logic signed [38:0] ap5;
	logic signed [38:0] ap2;
	logic signed [45:0] aa_s4;
	logic signed [38:0] ap5_s4;
	logic signed [38:0] ap2_s4;
	logic [15:0]        temp_s4;
	logic [19:0]        adc_p_s4;

	assign aa  = a_s3 * a_s3;
	assign ap5 = a_s3 * $signed(coef.p5);
	assign ap2 = a_s3 * $signed(coef.p2);

	// stage 5
	logic signed [61:0] aap6;
	logic signed [61:0] aap3;
	logic signed [63:0] bpart;
	logic signed [63:0] x2;
	logic signed [61:0] aap6_s5;
	logic signed [61:0] aap3_s5;
	logic signed [63:0] bpart_s5;
	logic signed [63:0] x2_s5;
	logic [15:0]        temp_s5;
	logic [19:0]        adc_p_s5;

	assign aap6  = aa_s4 * $signed(coef.p6);
	assign aap3  = aa_s4 * $signed(coef.p3);
	assign bpart = (64'(ap5_s4) <<< 17) + (64'($signed(coef.p4)) <<< 35);
	assign x2    = 64'(ap2_s4) <<< 12;

	// stage 6
	logic signed [63:0] b_sum;
	logic signed [63:0] s_sum;
	logic [63:0]        b_s6;
	logic signed [52:0] s_s6;
	logic [15:0]        temp_s6;
	logic [19:0]        adc_p_s6;

	assign b_sum = 64'(aap6_s5) + bpart_s5;
	assign s_sum = bpc_pkg::PRESS_OFFSET + (64'(aap3_s5) >>> 8) + x2_s5;

	// stage 7
	logic signed [69:0] prod;
	logic [20:0]        praw;
	logic [63:0]        pre;
	logic [63:0]        prod_s7;
	logic [63:0]        pre_s7;
	logic [15:0]        temp_s7;

	assign prod = s_s6 * $signed({1'b0, coef.p1});
	assign praw = bpc_pkg::ADC_FULL - {1'b0, adc_p_s6};
	assign pre  = {12'b0, praw, 31'b0} - b_s6;

	// stage 8
	logic [63:0]        num;
	logic [30:0]        dv_s8;
	logic [63:0]        num_s8;
	logic [15:0]        temp_s8;

	assign num = pre_s7 * bpc_pkg::NUM_SCALE;

	// stage 9: magnitudes for the divider
	logic [63:0] mag_n;
	logic [30:0] mag_d;
	logic [1:0]  status;
	logic        neg_s9;
	logic [1:0]  status_s9;
	logic [15:0] temp_s9;
	logic [63:0] mag_n_s9;
	logic [30:0] mag_d_s9;

	assign mag_n = num_s8[63] ? (64'd0 - num_s8) : num_s8;
	assign mag_d = dv_s8[30] ? (31'd0 - dv_s8) : dv_s8;

	always_comb begin
		priority if (!coef.present) begin
			status = bpc_pkg::STATUS_ABSENT;
		end else if (dv_s8 == '0) begin
			status = bpc_pkg::STATUS_DIV_ZERO;
		end else begin
			status = bpc_pkg::STATUS_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[8:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		x1_s1    <= x1_full[31:0];
		dd_s1    <= dd_full[31:0];
		adc_p_s1 <= sample.raw_pressure;

		v1_s2    <= $signed(x1_s1[31:11]);
		y_s2     <= y_full[31:0];
		adc_p_s2 <= adc_p_s1;

		temp_s3  <= fine5[23:8];
		a_s3     <= a_full;
		adc_p_s3 <= adc_p_s2;

		aa_s4    <= aa;
		ap5_s4   <= ap5;
		ap2_s4   <= ap2;
		temp_s4  <= temp_s3;
		adc_p_s4 <= adc_p_s3;

		aap6_s5  <= aap6;
		aap3_s5  <= aap3;
		bpart_s5 <= bpart;
		x2_s5    <= x2;
		temp_s5  <= temp_s4;
		adc_p_s5 <= adc_p_s4;

		b_s6     <= b_sum;
		s_s6     <= s_sum[52:0];
		temp_s6  <= temp_s5;
		adc_p_s6 <= adc_p_s5;

		prod_s7  <= prod[63:0];
		pre_s7   <= pre;
		temp_s7  <= temp_s6;

		dv_s8    <= prod_s7[63:33];
		num_s8   <= num;
		temp_s8  <= temp_s7;

		neg_s9    <= num_s8[63] ^ dv_s8[30];
		status_s9 <= status;
		temp_s9   <= temp_s8;
		mag_n_s9  <= mag_n;
		mag_d_s9  <= mag_d;
	end

	assign div_in = {vld_s[9], neg_s9, status_s9, temp_s9, mag_n_s9, mag_d_s9};

endmodule

[hdl/bpc_divider.sv]
// Unsigned restoring divider, one quotient bit per pipeline stage
`timescale 1ns / 1ps

module bpc_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  bpc_pkg::div_in_t   div_in,
	output bpc_pkg::div_out_t  div_out
);

	localparam int STAGES = bpc_pkg::QUOT_W;
	localparam int DW     = bpc_pkg::DIVISOR_W;

	// returns {quotient bit, next remainder}
	function automatic logic [DW:0] div_step(
		input logic [DW-1:0] rem,
		input logic          nbit,
		input logic [DW-1:0] dvs
	);
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		trial = {rem, nbit};
		diff  = {1'b0, trial} - {2'b00, dvs};
		if (diff[DW+1]) begin
			div_step = {1'b0, trial[DW-1:0]};
		end else begin
			div_step = {1'b1, diff[DW-1:0]};
		end
	endfunction

	logic [STAGES:1]      vld_s;
	logic [DW-1:0]        rem_s [1:STAGES];
	logic [STAGES-1:0]    quo_s [1:STAGES];
	logic [DW-1:0]        dvs_s [1:STAGES];
	bpc_pkg::div_tag_t    tag_s [1:STAGES];
	logic [DW:0]          step  [0:STAGES-1];

	always_comb begin
		step[0] = div_step('0, div_in.dividend[STAGES-1], div_in.divisor);
		for (int k = 1; k < STAGES; k++) begin
			step[k] = div_step(rem_s[k], quo_s[k][STAGES-1], dvs_s[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STAGES-1:1], div_in.vld};
		end
	end

	// dividend bits shift out the top while quotient bits fill from below
	always_ff @(posedge clk) begin
		rem_s[1] <= step[0][DW-1:0];
		quo_s[1] <= {div_in.dividend[STAGES-2:0], step[0][DW]};
		dvs_s[1] <= div_in.divisor;
		tag_s[1] <= div_in.tag;
		for (int k = 1; k < STAGES; k++) begin
			rem_s[k+1] <= step[k][DW-1:0];
			quo_s[k+1] <= {quo_s[k][STAGES-2:0], step[k][DW]};
			dvs_s[k+1] <= dvs_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign div_out.vld      = vld_s[STAGES];
	assign div_out.tag      = tag_s[STAGES];
	assign div_out.quotient = quo_s[STAGES];

endmodule

[hdl/bpc_back.sv]
// Post-division pressure correction, clamp and result register
`timescale 1ns / 1ps

module bpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bpc_pkg::div_out_t  div_out,
	input  bpc_pkg::coef_t     coef,
	output logic               done,
	output bpc_pkg::result_t   result
);

	logic [7:1] vld_s;

	// stage 1: restore quotient sign
	logic [63:0]       q_s1;
	bpc_pkg::div_tag_t tag_s1;

	// stage 2: square of q>>13 and q*P8, split into 32-bit halves
	logic [63:0]        t13;
	logic [63:0]        ll;
	logic [63:0]        lh_full;
	logic signed [48:0] qp8lo;
	logic [31:0]        qp8hi;
	logic [63:0]        ll_s2;
	logic [31:0]        lh_s2;
	logic signed [48:0] qp8lo_s2;
	logic [31:0]        qp8hi_s2;
	logic [63:0]        q_s2;
	bpc_pkg::div_tag_t  tag_s2;

	assign t13     = {{13{q_s1[63]}}, q_s1[63:13]};
	assign ll      = 64'(t13[31:0]) * 64'(t13[31:0]);
	assign lh_full = 64'(t13[31:0]) * 64'(t13[63:32]);
	assign qp8lo   = $signed({1'b0, q_s1[31:0]}) * $signed(coef.p8);
	assign qp8hi   = q_s1[63:32] * 32'($signed(coef.p8));

	// stage 3
	logic [63:0]        m1;
	logic signed [63:0] pe;
	logic [63:0]        m1_s3;
	logic signed [63:0] e_s3;
	logic [63:0]        q_s3;
	bpc_pkg::div_tag_t  tag_s3;

	assign m1 = ll_s2 + {lh_s2[30:0], 33'b0};
	assign pe = 64'(qp8lo_s2) + {qp8hi_s2, 32'b0};

	// stage 4: P9 times the square
	logic signed [48:0] m2lo;
	logic [31:0]        m2hi;
	logic signed [48:0] m2lo_s4;
	logic [31:0]        m2hi_s4;
	logic signed [63:0] e_s4;
	logic [63:0]        q_s4;
	bpc_pkg::div_tag_t  tag_s4;

	assign m2lo = $signed({1'b0, m1_s3[31:0]}) * $signed(coef.p9);
	assign m2hi = m1_s3[63:32] * 32'($signed(coef.p9));

	// stage 5
	logic signed [63:0] m2;
	logic signed [63:0] c_s5;
	logic [63:0]        sum1_s5;
	bpc_pkg::div_tag_t  tag_s5;

	assign m2 = 64'(m2lo_s4) + {m2hi_s4, 32'b0};

	// stage 6
	logic signed [63:0] s_s6;
	bpc_pkg::div_tag_t  tag_s6;

	// stage 7: P7 term, final shift and clamp
	logic signed [63:0] pf;
	logic [17:0]        press;

	assign pf = (s_s6 >>> 8) + (64'($signed(coef.p7)) <<< 4);

	always_comb begin
		priority if (pf[63]) begin
			press = '0;
		end else if (|pf[62:26]) begin
			press = bpc_pkg::PRESS_TOP;
		end else begin
			press = pf[25:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[6:1], div_out.vld};
		end
	end

	always_ff @(posedge clk) begin
		q_s1   <= div_out.tag.neg ? (64'd0 - div_out.quotient) : div_out.quotient;
		tag_s1 <= div_out.tag;

		ll_s2    <= ll;
		lh_s2    <= lh_full[31:0];
		qp8lo_s2 <= qp8lo;
		qp8hi_s2 <= qp8hi;
		q_s2     <= q_s1;
		tag_s2   <= tag_s1;

		m1_s3  <= m1;
		e_s3   <= pe >>> 19;
		q_s3   <= q_s2;
		tag_s3 <= tag_s2;

		m2lo_s4 <= m2lo;
		m2hi_s4 <= m2hi;
		e_s4    <= e_s3;
		q_s4    <= q_s3;
		tag_s4  <= tag_s3;

		c_s5    <= m2 >>> 25;
		sum1_s5 <= q_s4 + e_s4;
		tag_s5  <= tag_s4;

		s_s6   <= sum1_s5 + c_s5;
		tag_s6 <= tag_s5;

		result.result_status <= tag_s6.status;
		if (tag_s6.status == bpc_pkg::STATUS_VALID) begin
			result.temp_hundredths <= tag_s6.temp;
			result.press_pascal    <= press;
		end else begin
			result.temp_hundredths <= '0;
			result.press_pascal    <= '0;
		end
	end

	assign done = vld_s[7];

endmodule

[hdl/baro_pressure_compensation_top.sv]
// Top level of the barometric pressure/temperature compensation pipeline
//
// channel   ports                          transfer
// -------   -----------------------------  ----------------------------------
// input     start, busy, sample            beat taken when start && !busy
// result    done, result                   one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_data    register written when cfg_we high
//
// One beat per clock. A result passes through nine stages of temperature math
// and divisor setup, 64 stages of the restoring divider (one quotient bit each)
// and seven stages of correction and clamp.
// Reset clears the valid bits and the calibration registers.
// busy stays low; nothing in the pipe ever stalls.
`timescale 1ns / 1ps

module baro_pressure_compensation_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  bpc_pkg::sample_t                   sample,
	output logic                               done,
	output bpc_pkg::result_t                   result,
	input  logic                               cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                             present_q;
	logic [bpc_pkg::CFG_DATA_W-1:0]   temp_coef_q;
	logic [bpc_pkg::CFG_DATA_W-1:0]   press_a_q;
	logic [bpc_pkg::CFG_DATA_W-1:0]   press_b_q;
	logic [bpc_pkg::CFG_DATA_W-1:0]   press_c_q;

	bpc_pkg::coef_t    coef;
	bpc_pkg::div_in_t  div_in;
	bpc_pkg::div_out_t div_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= 1'b0;
			temp_coef_q <= '0;
			press_a_q   <= '0;
			press_b_q   <= '0;
			press_c_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::CFG_SENSOR_PRESENT: present_q   <= cfg_data[0];
				bpc_pkg::CFG_TEMP_COEF:      temp_coef_q <= cfg_data;
				bpc_pkg::CFG_PRESS_A:        press_a_q   <= cfg_data;
				bpc_pkg::CFG_PRESS_B:        press_b_q   <= cfg_data;
				bpc_pkg::CFG_PRESS_C:        press_c_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef.present = present_q;
	assign coef.t1 = temp_coef_q[15:0];
	assign coef.t2 = temp_coef_q[31:16];
	assign coef.t3 = temp_coef_q[47:32];
	assign coef.p1 = press_a_q[15:0];
	assign coef.p2 = press_a_q[31:16];
	assign coef.p3 = press_a_q[47:32];
	assign coef.p4 = press_b_q[15:0];
	assign coef.p5 = press_b_q[31:16];
	assign coef.p6 = press_b_q[47:32];
	assign coef.p7 = press_c_q[15:0];
	assign coef.p8 = press_c_q[31:16];
	assign coef.p9 = press_c_q[47:32];

	assign busy = 1'b0;

	bpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.sample (sample),
		.coef   (coef),
		.div_in (div_in)
	);

	bpc_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_in  (div_in),
		.div_out (div_out)
	);

	bpc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_out (div_out),
		.coef    (coef),
		.done    (done),
		.result  (result)
	);

endmodule

[hdl/bpc_checker.sv]
// Port-level checks of the compensation block, bound to its top level
`timescale 1ns / 1ps
`include "baro_pressure_compensation_top_defines.svh"

module bpc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             done,
	input bpc_pkg::result_t result
);

	logic flagged;
	logic fields_zero;
	logic status_known;

	assign flagged      = done && (result.result_status != bpc_pkg::STATUS_VALID);
	assign fields_zero  = (result.temp_hundredths == '0) && (result.press_pascal == '0);
	assign status_known = (result.result_status == bpc_pkg::STATUS_VALID)
		|| (result.result_status == bpc_pkg::STATUS_ABSENT)
		|| (result.result_status == bpc_pkg::STATUS_DIV_ZERO);

	// every strobe traces back to an input beat a fixed latency earlier
	`BPC_ASSERT_IMPLIES(a_done_has_beat, done, $past(start, bpc_pkg::PIPE_LATENCY))

	// flagged results carry zero fields
	`BPC_ASSERT_IMPLIES(a_flag_zero, flagged, fields_zero)

	`BPC_ASSERT_ALWAYS(a_status_code, !done || status_known)

endmodule

bind baro_pressure_compensation_top bpc_checker u_bpc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.done   (done),
	.result (result)
);

[bench/baro_pressure_compensation_top_tb.sv]
// Self-checking testbench for the barometric pressure/temperature compensation pipeline
`timescale 1ns / 1ps

module baro_pressure_compensation_top_tb;
	import bpc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int GAP_PCT     = 18;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	sample_t               sample;
	logic                  done;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow copy of the calibration registers
	logic                  sh_present;
	logic [CFG_DATA_W-1:0] sh_temp, sh_pa, sh_pb, sh_pc;

	result_t pending_results[$];
	int      error_count;
	int      idle_cycles;
	bit      gaps_on;

	baro_pressure_compensation_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint wrap32(longint x);
		int v;
		v = x[31:0];
		return v;
	endfunction

	function automatic logic [63:0] asr64(logic [63:0] x, int n);
		logic signed [63:0] s;
		s = x;
		return s >>> n;
	endfunction

	function automatic logic [63:0] sx16(logic [15:0] w);
		return {{48{w[15]}}, w};
	endfunction

	function automatic result_t compensate(sample_t s);
		longint adc_p, adc_t, t1, t2, t3, v1, v2, d, fine, tc;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] a, b, pv, num, mn, md, q, t13, c, e;
		logic signed [63:0] pres;
		result_t r;
		r = '0;
		if (!sh_present) begin
			r.result_status = STATUS_ABSENT;
			return r;
		end
		adc_p = s.raw_pressure;
		adc_t = s.raw_temperature;
		t1 = sh_temp[15:0];
		t2 = $signed(sh_temp[31:16]);
		t3 = $signed(sh_temp[47:32]);
		p1 = {48'b0, sh_pa[15:0]};
		p2 = sx16(sh_pa[31:16]);
		p3 = sx16(sh_pa[47:32]);
		p4 = sx16(sh_pb[15:0]);
		p5 = sx16(sh_pb[31:16]);
		p6 = sx16(sh_pb[47:32]);
		p7 = sx16(sh_pc[15:0]);
		p8 = sx16(sh_pc[31:16]);
		p9 = sx16(sh_pc[47:32]);

		// 32-bit temperature path
		v1 = wrap32(((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (adc_t >>> 4) - t1;
		v2 = wrap32((wrap32(d * d) >>> 12) * t3) >>> 14;
		fine = wrap32(v1 + v2);
		tc = wrap32(wrap32(fine * 5) + 128) >>> 8;

		// 64-bit pressure path, wraps mod 2^64
		a = fine - 128000;
		b = a * a * p6;
		b = b + ((a * p5) << 17);
		b = b + (p4 << 35);
		a = asr64(a * a * p3, 8) + ((a * p2) << 12);
		a = asr64(((64'd1 << 47) + a) * p1, 33);
		if (a == 64'd0) begin
			r.result_status = STATUS_DIV_ZERO;
			return r;
		end
		pv = 64'd1048576 - adc_p;
		num = ((pv << 31) - b) * 64'd3125;
		mn = num[63] ? -num : num;
		md = a[63] ? -a : a;
		q = mn / md;
		pv = (num[63] != a[63]) ? -q : q;
		t13 = asr64(pv, 13);
		c = asr64(p9 * t13 * t13, 25);
		e = asr64(p8 * pv, 19);
		pv = asr64(pv + c + e, 8) + (p7 << 4);
		pres = asr64(pv, 8);
		if (pres < 0)
			pres = 0;
		else if (pres > 64'sd262143)
			pres = PRESS_TOP;
		r.temp_hundredths = tc[15:0];
		r.press_pascal = pres[17:0];
		r.result_status = STATUS_VALID;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.temp_hundredths !== want.temp_hundredths)
					report_mismatch("temperature", result.temp_hundredths,
						want.temp_hundredths);
				if (result.press_pascal !== want.press_pascal)
					report_mismatch("pressure", result.press_pascal, want.press_pascal);
				if (result.result_status !== want.result_status)
					report_mismatch("status", result.result_status, want.result_status);
			end
		end
	end

	// watchdog on cycles where no beat moves either way
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("baro_pressure_compensation_top_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_sample(logic [19:0] raw_p, logic [19:0] raw_t);
		sample_t s;
		s.raw_pressure = raw_p;
		s.raw_temperature = raw_t;
		if (gaps_on) begin
			while ($urandom_range(99) < GAP_PCT) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy);
		pending_results.push_back(compensate(s));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SENSOR_PRESENT: sh_present = value[0];
			CFG_TEMP_COEF:      sh_temp = value;
			CFG_PRESS_A:        sh_pa = value;
			CFG_PRESS_B:        sh_pb = value;
			CFG_PRESS_C:        sh_pc = value;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] jitter(logic [15:0] w, int span);
		return w + 16'($urandom_range(0, 2 * span)) - 16'(span);
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// typical factory calibration, optionally perturbed
	task automatic load_nominal(int span);
		write_reg(CFG_TEMP_COEF, {jitter(-16'sd1000, span), jitter(16'd26435, span),
			jitter(16'd27504, span)});
		write_reg(CFG_PRESS_A, {jitter(16'd3024, span), jitter(-16'sd10685, span),
			jitter(16'd36477, span)});
		write_reg(CFG_PRESS_B, {jitter(-16'sd7, span), jitter(16'd140, span),
			jitter(16'd2855, span)});
		write_reg(CFG_PRESS_C, {jitter(16'd6000, span), jitter(-16'sd14600, span),
			jitter(16'd15500, span)});
	endtask

	task automatic send_edge_samples();
		send_sample(20'd415148, 20'd519888);
		send_sample(20'h00000, 20'h00000);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h00000, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'h00000);
		send_sample(20'h55555, 20'hAAAAA);
	endtask

	task automatic test_sensor_absent();
		send_edge_samples();
		drain();
		write_reg(CFG_SENSOR_PRESENT, 48'hFFFF_FFFF_FFFE);
		send_sample(20'd415148, 20'd519888);
		drain();
	endtask

	task automatic test_nominal();
		write_reg(CFG_SENSOR_PRESENT, 48'h8000_0000_0001);
		load_nominal(0);
		send_edge_samples();
		drain();
		// writes to unused indexes must leave calibration untouched
		for (int i = CFG_PRESS_C + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), rand48());
		send_sample(20'd300000, 20'd500000);
		drain();
	endtask

	task automatic test_zero_divisor();
		write_reg(CFG_PRESS_A, {16'd3024, -16'sd10685, 16'd0});
		send_sample(20'd415148, 20'd519888);
		send_sample(20'hFFFFF, 20'h12345);
		drain();
	endtask

	task automatic test_extreme_words();
		write_reg(CFG_TEMP_COEF, {16'h7FFF, 16'h8000, 16'hFFFF});
		write_reg(CFG_PRESS_A, {16'h8000, 16'h7FFF, 16'hFFFF});
		write_reg(CFG_PRESS_B, {16'h7FFF, 16'h8000, 16'h7FFF});
		write_reg(CFG_PRESS_C, {16'h8000, 16'h7FFF, 16'h8000});
		send_edge_samples();
		drain();
		write_reg(CFG_TEMP_COEF, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_PRESS_A, 48'h0000_0000_0001);
		write_reg(CFG_PRESS_B, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_PRESS_C, 48'h7FFF_7FFF_7FFF);
		send_edge_samples();
		drain();
	endtask

	task automatic test_random();
		int kind;
		for (int phase = 0; phase < 12; phase++) begin
			kind = $urandom_range(99);
			gaps_on = (phase != 5);
			write_reg(CFG_SENSOR_PRESENT, {47'(rand48() >> 1), $urandom_range(99) < 90});
			if (kind < 65) begin
				load_nominal(400);
			end else if (kind < 90) begin
				write_reg(CFG_TEMP_COEF, rand48());
				write_reg(CFG_PRESS_A, rand48());
				write_reg(CFG_PRESS_B, rand48());
				write_reg(CFG_PRESS_C, rand48());
			end else begin
				load_nominal(0);
				write_reg(CFG_PRESS_A, {32'(rand48() >> 16), 16'($urandom_range(0, 3))});
			end
			repeat (58) begin
				if ($urandom_range(99) < 60)
					send_sample(20'($urandom_range(200000, 700000)),
						20'($urandom_range(380000, 620000)));
				else
					send_sample(20'($urandom_range(0, 20'hFFFFF)),
						20'($urandom_range(0, 20'hFFFFF)));
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sh_present = 1'b0;
		sh_temp = '0;
		sh_pa = '0;
		sh_pb = '0;
		sh_pc = '0;
		error_count = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sensor_absent();
		test_nominal();
		test_zero_divisor();
		test_extreme_words();
		test_random();

		drain();
		repeat (PIPE_LATENCY + 20) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		if (error_count == 0)
			$display("baro_pressure_compensation_top_tb: clean");
		else
			$display("baro_pressure_compensation_top_tb: errors");
		$finish;
	end

endmodule
